// ===== src/weighted_bipartite_matching_greedy_top_defines.svh =====
// Assertion macros for the bipartite matching block.
`ifndef WEIGHTED_BIPARTITE_MATCHING_GREEDY_TOP_DEFINES_SVH
`define WEIGHTED_BIPARTITE_MATCHING_GREEDY_TOP_DEFINES_SVH

`ifndef SYNTHESIS
`define WBM_ASSERT_IMPLY(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("wbm: check failed");
`define WBM_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("wbm: check failed");
`else
`define WBM_ASSERT_IMPLY(label, ante, cons)
`define WBM_ASSERT_NEXT(label, ante, cons)
`endif

`endif

// ===== src/wbm_pkg.sv =====
package wbm_pkg;

  localparam int PartnerW = 5;

  typedef enum logic [1:0] {
    KIND_WEIGHT = 2'd0,
    KIND_EDGE   = 2'd1,
    KIND_SOLVE  = 2'd2,
    KIND_NONE   = 2'd3
  } kind_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_SORT_LD,
    S_SORT_W,
    S_SORT_RQ,
    S_SORT_CMP,
    S_ROOT,
    S_TOP,
    S_EDGE,
    S_AUG_RD,
    S_AUG_WR,
    S_EMIT
  } state_t;

endpackage

// ===== src/weighted_bipartite_matching_greedy_top.sv =====
// Greedy weighted bipartite matching. Weight items (kind 0) and edge items (kind 1) are one
// memory write each. A solve item (kind 2) sorts the left vertices by falling weight with
// an insertion sort (each comparison waits on the single read port of the weight memory),
// then runs a depth-first augmenting-path search per vertex; each edge tried and each
// augmenting step waits on the registered read of the adjacency memory. The run then emits
// one result per vertex in use, one per cycle while out_ready is high, and clears the lists
// and the matching. No item is taken while a solve is in progress.
`include "weighted_bipartite_matching_greedy_top_defines.svh"
module weighted_bipartite_matching_greedy_top #(
  parameter int MAX_VERTICES = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_write_en,
  input  logic [4:0]  cfg_vertex_count,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_kind,
  input  logic [3:0]  in_vertex,
  input  logic [3:0]  in_neighbour,
  input  logic signed [31:0] in_weight,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [3:0]  out_left_vertex,
  output logic [wbm_pkg::PartnerW-1:0] out_partner,
  output logic        out_last
);
  import wbm_pkg::*;

  localparam int ACT = (MAX_VERTICES < 16) ? MAX_VERTICES : 16;
  localparam int IW  = $clog2(ACT);
  localparam int CW  = $clog2(ACT + 1);
  localparam int EW  = $clog2(MAX_VERTICES + 1);
  localparam int AW  = $clog2(ACT * MAX_VERTICES);

  state_t state_r, state_nxt;
  logic [4:0] cnt_r;
  logic [CW-1:0] n;
  logic [CW-1:0] i_r, i_nxt, j_r, j_nxt, sp_r, sp_nxt, k_r, k_nxt;
  logic signed [31:0] wcur_r, wcur_nxt;
  logic out_valid_r, out_valid_nxt;
  logic [3:0] out_lv_r;
  logic [PartnerW-1:0] out_partner_r;
  logic out_last_r;

  logic [EW-1:0] len_r [ACT];
  logic [CW-1:0] rp_r [ACT];
  logic [PartnerW-1:0] lp_r [ACT];
  logic [ACT-1:0] vis_r;
  logic [IW-1:0] stv_r [ACT];
  logic [EW-1:0] ste_r [ACT];
  logic [IW-1:0] ord_r [ACT];

  logic w_we;
  logic [IW-1:0] w_raddr;
  logic signed [31:0] w_rdata;
  logic a_we;
  logic [AW-1:0] a_waddr, a_raddr;
  logic [3:0] a_rdata;

  logic in_fire, v_ok, ld_out, i_last;
  kind_t kind;
  logic [CW-1:0] spm1, jm1;
  logic [IW-1:0] top, fk, to_i, u;
  logic [IW-1:0] top_v, fv;
  logic [EW-1:0] top_e, fe;
  logic edge_end, to_ok, free_to, sp_full;
  logic [CW-1:0] rp_to;

  wbm_ram #(.Width(32), .Depth(ACT)) u_weight (
    .clk(clk), .we(w_we), .waddr(in_vertex[IW-1:0]), .wdata(in_weight),
    .raddr(w_raddr), .rdata(w_rdata)
  );

  wbm_ram #(.Width(4), .Depth(ACT * MAX_VERTICES)) u_adj (
    .clk(clk), .we(a_we), .waddr(a_waddr), .wdata(in_neighbour),
    .raddr(a_raddr), .rdata(a_rdata)
  );

  assign kind    = kind_t'(in_kind);
  assign in_ready = (state_r == S_IDLE);
  assign in_fire = in_valid && in_ready;
  assign v_ok    = int'(in_vertex) < ACT;
  assign n = (cnt_r == 5'd0) ? CW'(1) : ((int'(cnt_r) > ACT) ? CW'(ACT) : CW'(cnt_r));
  assign i_last  = (i_r == n - CW'(1));

  assign spm1    = sp_r - CW'(1);
  assign jm1     = j_r - CW'(1);
  assign top     = spm1[IW-1:0];
  assign top_v   = stv_r[top];
  assign top_e   = ste_r[top];
  assign edge_end = top_e >= len_r[top_v];
  assign to_ok   = 5'(a_rdata) < 5'(n);
  assign to_i    = a_rdata[IW-1:0];
  assign rp_to   = rp_r[to_i];
  assign free_to = (rp_to == CW'(0));
  assign u       = IW'(rp_to - CW'(1));
  assign sp_full = int'(sp_r) >= MAX_VERTICES;
  assign fk      = k_r[IW-1:0];
  assign fv      = stv_r[fk];
  assign fe      = ste_r[fk] - EW'(1);

  assign w_we    = in_fire && (kind == KIND_WEIGHT) && v_ok;
  assign a_we    = in_fire && (kind == KIND_EDGE) && v_ok &&
                   (int'(len_r[in_vertex[IW-1:0]]) < MAX_VERTICES);
  assign a_waddr = AW'(in_vertex[IW-1:0]) * AW'(MAX_VERTICES) +
                   AW'(len_r[in_vertex[IW-1:0]]);

  always_comb begin
    state_nxt = state_r;
    i_nxt = i_r;
    j_nxt = j_r;
    sp_nxt = sp_r;
    k_nxt = k_r;
    wcur_nxt = wcur_r;
    ld_out = 1'b0;
    w_raddr = i_r[IW-1:0];
    a_raddr = AW'(top_v) * AW'(MAX_VERTICES) + AW'(top_e);
    case (state_r)
      S_IDLE: begin
        if (in_fire && kind == KIND_SOLVE) begin
          i_nxt = '0;
          state_nxt = S_SORT_LD;
        end
      end
      S_SORT_LD: state_nxt = S_SORT_W;
      S_SORT_W: begin
        wcur_nxt = w_rdata;
        j_nxt = i_r;
        state_nxt = S_SORT_RQ;
      end
      S_SORT_RQ: begin
        w_raddr = ord_r[jm1[IW-1:0]];
        if (j_r == CW'(0)) begin
          i_nxt = i_last ? CW'(0) : i_r + CW'(1);
          state_nxt = i_last ? S_ROOT : S_SORT_LD;
        end else begin
          state_nxt = S_SORT_CMP;
        end
      end
      S_SORT_CMP: begin
        if (wcur_r > w_rdata) begin
          j_nxt = jm1;
          state_nxt = S_SORT_RQ;
        end else begin
          i_nxt = i_last ? CW'(0) : i_r + CW'(1);
          state_nxt = i_last ? S_ROOT : S_SORT_LD;
        end
      end
      S_ROOT: begin
        if (i_r == n) begin
          i_nxt = '0;
          state_nxt = S_EMIT;
        end else begin
          sp_nxt = CW'(1);
          state_nxt = S_TOP;
        end
      end
      S_TOP: begin
        if (sp_r == CW'(0)) begin
          i_nxt = i_r + CW'(1);
          state_nxt = S_ROOT;
        end else if (edge_end) begin
          sp_nxt = spm1;
        end else begin
          state_nxt = S_EDGE;
        end
      end
      S_EDGE: begin
        state_nxt = S_TOP;
        if (to_ok) begin
          if (free_to) begin
            k_nxt = spm1;
            state_nxt = S_AUG_RD;
          end else if (!vis_r[u] && !sp_full) begin
            sp_nxt = sp_r + CW'(1);
          end
        end
      end
      S_AUG_RD: begin
        a_raddr = AW'(fv) * AW'(MAX_VERTICES) + AW'(fe);
        state_nxt = S_AUG_WR;
      end
      S_AUG_WR: begin
        if (k_r == CW'(0)) begin
          i_nxt = i_r + CW'(1);
          state_nxt = S_ROOT;
        end else begin
          k_nxt = k_r - CW'(1);
          state_nxt = S_AUG_RD;
        end
      end
      S_EMIT: begin
        if (!out_valid_r || out_ready) begin
          ld_out = 1'b1;
          i_nxt = i_r + CW'(1);
          if (i_last) begin
            state_nxt = S_IDLE;
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
    out_valid_nxt = ld_out ? 1'b1 : (out_ready ? 1'b0 : out_valid_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r <= 5'd16;
      out_valid_r <= 1'b0;
      i_r <= '0;
      j_r <= '0;
      sp_r <= '0;
      k_r <= '0;
    end else begin
      state_r <= state_nxt;
      if (cfg_write_en) begin
        cnt_r <= cfg_vertex_count;
      end
      out_valid_r <= out_valid_nxt;
      i_r <= i_nxt;
      j_r <= j_nxt;
      sp_r <= sp_nxt;
      k_r <= k_nxt;
    end
  end

  // payload and stack storage, no reset
  always_ff @(posedge clk) begin
    wcur_r <= wcur_nxt;
    if (ld_out) begin
      out_lv_r <= 4'(i_r);
      out_partner_r <= lp_r[i_r[IW-1:0]];
      out_last_r <= i_last;
    end
    case (state_r)
      S_SORT_RQ: begin
        if (j_r == CW'(0)) begin
          ord_r[0] <= i_r[IW-1:0];
        end
      end
      S_SORT_CMP: begin
        // shift the earlier vertex up, or drop the current one in place
        ord_r[j_r[IW-1:0]] <= (wcur_r > w_rdata) ? ord_r[jm1[IW-1:0]] : i_r[IW-1:0];
      end
      S_ROOT: begin
        stv_r[0] <= ord_r[i_r[IW-1:0]];
        ste_r[0] <= '0;
      end
      S_TOP: begin
        if (sp_r != CW'(0) && !edge_end) begin
          ste_r[top] <= top_e + EW'(1);
        end
      end
      S_EDGE: begin
        if (to_ok && !free_to && !vis_r[u] && !sp_full) begin
          stv_r[sp_r[IW-1:0]] <= u;
          ste_r[sp_r[IW-1:0]] <= '0;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vis_r <= '0;
      for (int e = 0; e < ACT; e++) begin
        len_r[e] <= '0;
        rp_r[e] <= '0;
        lp_r[e] <= '0;
      end
    end else begin
      if (a_we) begin
        len_r[in_vertex[IW-1:0]] <= len_r[in_vertex[IW-1:0]] + EW'(1);
      end
      if (state_r == S_ROOT && i_r != n) begin
        vis_r <= ACT'(1) << ord_r[i_r[IW-1:0]];
      end
      if (state_r == S_EDGE && to_ok && !free_to && !vis_r[u] && !sp_full) begin
        vis_r[u] <= 1'b1;
      end
      if (state_r == S_AUG_WR) begin
        rp_r[to_i] <= CW'(fv) + CW'(1);
        lp_r[fv] <= PartnerW'(a_rdata) + PartnerW'(1);
      end
      if (ld_out && i_last) begin
        for (int e = 0; e < ACT; e++) begin
          len_r[e] <= '0;
          rp_r[e] <= '0;
          lp_r[e] <= '0;
        end
      end
    end
  end

  assign out_valid = out_valid_r;
  assign out_left_vertex = out_lv_r;
  assign out_partner = out_partner_r;
  assign out_last = out_last_r;

  `WBM_ASSERT_IMPLY(a_sp_bound, state_r != S_IDLE, int'(sp_r) <= ACT)
  `WBM_ASSERT_IMPLY(a_aug_target, state_r == S_AUG_WR, 5'(a_rdata) < 5'(n))
  `WBM_ASSERT_NEXT(a_solve_busy, in_fire && kind == KIND_SOLVE, !in_ready)
endmodule

// ===== src/wbm_ram.sv =====
module wbm_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0]         wdata,
  input  logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
